>>> rtl/core/afcd_pkg.sv
// shared types, constants and the bytewise crc-32 step for the ascii frame deframer
// no dependencies; used by afcd_front, afcd_back and ascii_frame_crc_deframer
`default_nettype none

package afcd_pkg;

    // frame layout
    localparam int NAME_CHARS  = 5;
    localparam int SIZE_DIGITS = 3;
    localparam int MIN_SIZE    = 11;
    localparam int HEX_DIGITS  = 8;
    localparam int TAIL_BYTES  = 2;

    localparam int NAME_W = 40;
    localparam int SIZE_W = 10;
    localparam int POS_W  = 10;

    localparam logic [7:0]  CHAR_START = 8'h45;  // 'E'
    localparam logic [7:0]  CHAR_COMMA = 8'h2c;  // ','
    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_INIT   = 32'hffffffff;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SEP1,
        PH_NAME,
        PH_SEP2,
        PH_SIZE,
        PH_SEP3,
        PH_PAY,
        PH_FOOT_H,
        PH_HEX,
        PH_TAIL
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_SEP = 2'd1,
        STATUS_SHORT   = 2'd2,
        STATUS_CRC_BAD = 2'd3
    } status_t;

    // classified input word
    typedef struct packed {
        logic [7:0] data;
        logic       is_start;
        logic       is_comma;
        logic       is_dec;
        logic [3:0] dec_val;
        logic       is_hex;
        logic [3:0] hex_val;
    } class_word_t;

    // result word
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         payload_byte;
        status_t            status;
        logic [NAME_W-1:0]  frame_name;
        logic [SIZE_W-1:0]  decoded_size;
    } result_t;

    // one byte of reflected crc-32, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/afcd_front.sv
// front end: accepts received bytes, classifies them and holds them in a two-entry queue
// depends on afcd_pkg
`default_nettype none

module afcd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [7:0]            rx_byte,
    output logic                       full,
    output afcd_pkg::class_word_t      word_out,
    output logic                       word_valid,
    input  wire logic                  word_take
);

    afcd_pkg::class_word_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    afcd_pkg::class_word_t cls;
    logic       do_push;
    logic       do_pop;

    // classify the incoming byte
    always_comb
    begin
        cls.data     = rx_byte;
        cls.is_start = (rx_byte == afcd_pkg::CHAR_START);
        cls.is_comma = (rx_byte == afcd_pkg::CHAR_COMMA);
        cls.is_dec   = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
        cls.dec_val  = rx_byte[3:0];
        cls.is_hex   = 1'b0;
        cls.hex_val  = 4'd0;
        if (cls.is_dec)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = rx_byte[3:0];
        end
        else if (((rx_byte >= 8'h61) && (rx_byte <= 8'h66)) ||
                 ((rx_byte >= 8'h41) && (rx_byte <= 8'h46)))
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(rx_byte[3:0] + 4'd9);
        end
    end

    // queue control
    assign full       = (count_reg == 2'd2);
    assign word_valid = (count_reg != 2'd0);
    assign word_out   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = word_take && word_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = 2'(count_reg + 2'd1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = 2'(count_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/afcd_back.sv
// back end: frame parser, crc-32 and two-entry result queue
// depends on afcd_pkg
`default_nettype none

module afcd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire afcd_pkg::class_word_t word_in,
    input  wire logic                  word_valid,
    output logic                       word_take,
    input  wire logic                  pop,
    output logic                       empty,
    output afcd_pkg::result_t          result
);

    afcd_pkg::phase_t                phase_reg, phase_next;
    logic [afcd_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [afcd_pkg::NAME_W-1:0]     name_reg, name_next;
    logic [afcd_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic                            size_ok_reg, size_ok_next;
    logic [31:0]                     crc_reg, crc_next;
    logic [31:0]                     rx_crc_reg, rx_crc_next;
    logic                            hex_ok_reg, hex_ok_next;

    afcd_pkg::result_t               res_mem_reg [2];
    logic                            res_wr_reg, res_rd_reg;
    logic [1:0]                      res_count_reg, res_count_next;

    logic                            emit;
    afcd_pkg::kind_t                 emit_kind;
    afcd_pkg::status_t               emit_status;
    logic [7:0]                      emit_byte;
    afcd_pkg::result_t               res_word;
    logic [13:0]                     size_prod;
    logic [afcd_pkg::POS_W-1:0]      pos_inc;
    logic                            do_res_pop;

    assign word_take  = word_valid && (res_count_reg != 2'd2);
    assign pos_inc    = afcd_pkg::POS_W'(pos_reg + 1'b1);
    assign size_prod  = 14'({4'b0, size_reg} * 14'd10) + {10'b0, word_in.dec_val};

    // parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        name_next    = name_reg;
        size_next    = size_reg;
        size_ok_next = size_ok_reg;
        crc_next     = crc_reg;
        rx_crc_next  = rx_crc_reg;
        hex_ok_next  = hex_ok_reg;
        emit         = 1'b0;
        emit_kind    = afcd_pkg::KIND_REPORT;
        emit_status  = afcd_pkg::STATUS_OK;
        emit_byte    = 8'd0;

        if (word_take)
        begin
            case (phase_reg)
                afcd_pkg::PH_HUNT:
                begin
                    if (word_in.is_start)
                    begin
                        name_next    = '0;
                        size_next    = '0;
                        size_ok_next = 1'b1;
                        rx_crc_next  = '0;
                        hex_ok_next  = 1'b1;
                        pos_next     = '0;
                        crc_next     = afcd_pkg::crc_byte(afcd_pkg::CRC_INIT, word_in.data);
                        phase_next   = afcd_pkg::PH_SEP1;
                    end
                end
                afcd_pkg::PH_SEP1, afcd_pkg::PH_SEP2, afcd_pkg::PH_SEP3:
                begin
                    crc_next = afcd_pkg::crc_byte(crc_reg, word_in.data);
                    pos_next = '0;
                    if (!word_in.is_comma)
                    begin
                        emit        = 1'b1;
                        emit_status = afcd_pkg::STATUS_BAD_SEP;
                        phase_next  = afcd_pkg::PH_HUNT;
                    end
                    else if (phase_reg == afcd_pkg::PH_SEP1)
                    begin
                        phase_next = afcd_pkg::PH_NAME;
                    end
                    else if (phase_reg == afcd_pkg::PH_SEP2)
                    begin
                        phase_next = afcd_pkg::PH_SIZE;
                    end
                    else if (size_reg > afcd_pkg::SIZE_W'(afcd_pkg::MIN_SIZE))
                    begin
                        phase_next = afcd_pkg::PH_PAY;
                    end
                    else
                    begin
                        phase_next = afcd_pkg::PH_FOOT_H;
                    end
                end
                afcd_pkg::PH_NAME:
                begin
                    crc_next  = afcd_pkg::crc_byte(crc_reg, word_in.data);
                    name_next = {name_reg[afcd_pkg::NAME_W-9:0], word_in.data};
                    pos_next  = pos_inc;
                    if (pos_inc >= afcd_pkg::POS_W'(afcd_pkg::NAME_CHARS))
                    begin
                        phase_next = afcd_pkg::PH_SEP2;
                    end
                end
                afcd_pkg::PH_SIZE:
                begin
                    crc_next = afcd_pkg::crc_byte(crc_reg, word_in.data);
                    if (size_ok_reg && word_in.is_dec)
                    begin
                        size_next = (size_prod > 14'd1023) ? '1 : size_prod[afcd_pkg::SIZE_W-1:0];
                    end
                    else
                    begin
                        size_ok_next = 1'b0;
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= afcd_pkg::POS_W'(afcd_pkg::SIZE_DIGITS))
                    begin
                        if (size_next < afcd_pkg::SIZE_W'(afcd_pkg::MIN_SIZE))
                        begin
                            emit        = 1'b1;
                            emit_status = afcd_pkg::STATUS_SHORT;
                            pos_next    = '0;
                            phase_next  = afcd_pkg::PH_HUNT;
                        end
                        else
                        begin
                            phase_next = afcd_pkg::PH_SEP3;
                        end
                    end
                end
                afcd_pkg::PH_PAY:
                begin
                    crc_next  = afcd_pkg::crc_byte(crc_reg, word_in.data);
                    pos_next  = pos_inc;
                    emit      = 1'b1;
                    emit_kind = afcd_pkg::KIND_PAYLOAD;
                    emit_byte = word_in.data;
                    if (pos_inc >= afcd_pkg::POS_W'(size_reg - afcd_pkg::SIZE_W'(afcd_pkg::MIN_SIZE)))
                    begin
                        phase_next = afcd_pkg::PH_FOOT_H;
                    end
                end
                afcd_pkg::PH_FOOT_H:
                begin
                    pos_next   = '0;
                    phase_next = afcd_pkg::PH_HEX;
                end
                afcd_pkg::PH_HEX:
                begin
                    if (hex_ok_reg && word_in.is_hex)
                    begin
                        rx_crc_next = {rx_crc_reg[27:0], word_in.hex_val};
                    end
                    else
                    begin
                        hex_ok_next = 1'b0;
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= afcd_pkg::POS_W'(afcd_pkg::HEX_DIGITS))
                    begin
                        pos_next   = '0;
                        phase_next = afcd_pkg::PH_TAIL;
                    end
                end
                afcd_pkg::PH_TAIL:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= afcd_pkg::POS_W'(afcd_pkg::TAIL_BYTES))
                    begin
                        emit        = 1'b1;
                        emit_status = ((~crc_reg) == rx_crc_reg) ? afcd_pkg::STATUS_OK
                                                                 : afcd_pkg::STATUS_CRC_BAD;
                        pos_next    = '0;
                        phase_next  = afcd_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    pos_next   = '0;
                    phase_next = afcd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // result word, carries name and size as they stand after this byte
    always_comb
    begin
        res_word.kind         = emit_kind;
        res_word.payload_byte = emit_byte;
        res_word.status       = emit_status;
        res_word.frame_name   = name_next;
        res_word.decoded_size = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= afcd_pkg::PH_HUNT;
            pos_reg     <= '0;
            name_reg    <= '0;
            size_reg    <= '0;
            size_ok_reg <= 1'b1;
            crc_reg     <= afcd_pkg::CRC_INIT;
            rx_crc_reg  <= '0;
            hex_ok_reg  <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            name_reg    <= name_next;
            size_reg    <= size_next;
            size_ok_reg <= size_ok_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
            hex_ok_reg  <= hex_ok_next;
        end
    end

    // result queue control
    assign empty      = (res_count_reg == 2'd0);
    assign result     = res_mem_reg[res_rd_reg];
    assign do_res_pop = pop && !empty;

    always_comb
    begin
        res_count_next = res_count_reg;
        if (emit && !do_res_pop)
        begin
            res_count_next = 2'(res_count_reg + 2'd1);
        end
        else if (!emit && do_res_pop)
        begin
            res_count_next = 2'(res_count_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                res_wr_reg <= ~res_wr_reg;
            end
            if (do_res_pop)
            begin
                res_rd_reg <= ~res_rd_reg;
            end
            res_count_reg <= res_count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_mem_reg[res_wr_reg] <= res_word;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ascii_frame_crc_deframer.sv
// ascii_frame_crc_deframer: received bytes in, payload words and end-of-frame reports out.
// Input side: push a byte on rx_byte when full is low; one byte per cycle is taken.
// Output side: while empty is low the oldest result is on kind, payload_byte, status,
// frame_name and decoded_size; pop takes it. kind 0 is a payload byte, kind 1 a report
// with status ok, bad separator, size too small or crc mismatch.
// Path: a byte accepted into the front classify queue is read by the parser, which writes its
// result, if any, into the result queue that drives the result ports.
// Throughput: one byte per cycle, set by the parser and bytewise crc, while the result queue has room.
// Each side has a two-entry queue, so a stalled receiver fills the result queue,
// then the classify queue, and only then is full raised; no word is lost.
// Reset: both queues empty, parser hunting for 'E', crc at all ones.
// Depends on afcd_pkg, afcd_front, afcd_back.
`default_nettype none

module ascii_frame_crc_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   full,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   kind,
    output logic [7:0]                             payload_byte,
    output logic [1:0]                             status,
    output logic [afcd_pkg::NAME_W-1:0]            frame_name,
    output logic [afcd_pkg::SIZE_W-1:0]            decoded_size
);

    afcd_pkg::class_word_t word;
    logic                  word_valid;
    logic                  word_take;
    afcd_pkg::result_t     result;

    // classify front end
    afcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rx_byte    (rx_byte),
        .full       (full),
        .word_out   (word),
        .word_valid (word_valid),
        .word_take  (word_take)
    );

    // parser back end
    afcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_in    (word),
        .word_valid (word_valid),
        .word_take  (word_take),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    // result fields
    assign kind         = result.kind;
    assign payload_byte = result.payload_byte;
    assign status       = result.status;
    assign frame_name   = result.frame_name;
    assign decoded_size = result.decoded_size;

endmodule

`default_nettype wire
